// File: hw/rtl/hlts_pkg.sv
// ----------------------------------------------------------------------------
// hlts_pkg
// Shared types, constants and byte classes for the HTML link tag scanner.
// ----------------------------------------------------------------------------
package hlts_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned URL_LEN_W  = 11;
    localparam int unsigned TEXT_LEN_W = 9;
    localparam int unsigned STEP_W     = 4;

    localparam logic [URL_LEN_W-1:0]  URL_MAX  = 11'd1024;
    localparam logic [TEXT_LEN_W-1:0] TEXT_MAX = 9'd256;

    // highest byte value treated as whitespace
    localparam logic [BYTE_W-1:0] CH_BLANK = 8'd32;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_CASE  = 8'h20;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 3'd0,
        EV_URL         = 3'd1,
        EV_TEXT        = 3'd2,
        EV_ANCHOR_DONE = 3'd3,
        EV_FRAME_DONE  = 3'd4
    } t_event;

    // classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ws;
        logic              lt;
        logic              gt;
        logic              eq;
        logic              slash;
        logic              quote;
        logic              l_a;
        logic              l_c;
        logic              l_e;
        logic              l_f;
        logic              l_h;
        logic              l_m;
        logic              l_r;
        logic              l_s;
    } t_cls;

endpackage

// File: hw/rtl/hlts_if.sv
// ----------------------------------------------------------------------------
// hlts_in_if / hlts_out_if
// Valid/ready channels for the input byte and the result beat.
// ----------------------------------------------------------------------------
interface hlts_in_if;
    import hlts_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hlts_out_if;
    import hlts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [EVENT_W-1:0]    event_kind;
    logic [BYTE_W-1:0]     out_byte;
    logic [URL_LEN_W-1:0]  url_length;
    logic [TEXT_LEN_W-1:0] text_length;
    logic                  overflow;

    modport source (output valid, output event_kind, output out_byte,
                    output url_length, output text_length, output overflow,
                    input ready);
    modport sink   (input valid, input event_kind, input out_byte,
                    input url_length, input text_length, input overflow,
                    output ready);
endinterface

// File: hw/rtl/hlts_front.sv
// ----------------------------------------------------------------------------
// hlts_front
// Accepts input bytes and classifies them for the scanner back end.
// ----------------------------------------------------------------------------
module hlts_front (
    hlts_in_if.sink          i_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output hlts_pkg::t_cls   o_cls
);
    import hlts_pkg::*;

    logic [BYTE_W-1:0] lower;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;
    assign lower      = i_in.data_byte | CH_CASE;

    always_comb begin
        o_cls       = '0;
        o_cls.data  = i_in.data_byte;
        o_cls.ws    = (i_in.data_byte <= CH_BLANK);
        o_cls.lt    = (i_in.data_byte == CH_LT);
        o_cls.gt    = (i_in.data_byte == CH_GT);
        o_cls.eq    = (i_in.data_byte == CH_EQ);
        o_cls.slash = (i_in.data_byte == CH_SLASH);
        o_cls.quote = (i_in.data_byte == CH_QUOTE);
        o_cls.l_a   = (lower == 8'h61);
        o_cls.l_c   = (lower == 8'h63);
        o_cls.l_e   = (lower == 8'h65);
        o_cls.l_f   = (lower == 8'h66);
        o_cls.l_h   = (lower == 8'h68);
        o_cls.l_m   = (lower == 8'h6D);
        o_cls.l_r   = (lower == 8'h72);
        o_cls.l_s   = (lower == 8'h73);
    end

endmodule

// File: hw/rtl/hlts_queue.sv
// ----------------------------------------------------------------------------
// hlts_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hlts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hlts_pkg::t_cls   i_cls,
    output logic             o_ready,
    input  logic             i_pop,
    output hlts_pkg::t_cls   o_cls,
    output logic             o_valid
);
    import hlts_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cls   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = 2'(r_count + 2'd1);
        end else if (!i_push && i_pop && o_valid) begin
            n_count = 2'(r_count - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

// File: hw/rtl/hlts_back.sv
// ----------------------------------------------------------------------------
// hlts_back
// Tag matcher, length counters and registered result beat.
// ----------------------------------------------------------------------------
module hlts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hlts_pkg::t_cls   i_cls,
    input  logic             i_cls_valid,
    output logic             o_pop,
    hlts_out_if.source       o_out
);
    import hlts_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_ANCHOR = 4'b0010,
        MODE_FRAME  = 4'b0100,
        MODE_TEXT   = 4'b1000
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [URL_LEN_W-1:0]  r_url, n_url;
    logic [TEXT_LEN_W-1:0] r_text, n_text;
    logic                  r_ovf, n_ovf;

    logic                  r_out_valid;
    t_event                r_event, n_event;
    logic [BYTE_W-1:0]     r_echo, n_echo;
    logic [URL_LEN_W-1:0]  r_url_len;
    logic [TEXT_LEN_W-1:0] r_text_len;
    logic                  r_out_ovf;

    logic pop;
    logic skip;
    logic want_url;
    logic want_text;
    logic done;

    assign pop   = i_cls_valid && (!r_out_valid || o_out.ready);
    assign o_pop = pop;

    always_comb begin
        skip = 1'b0;
        if (i_cls.ws) begin
            unique case (r_mode)
                MODE_IDLE:   skip = 1'b1;
                MODE_ANCHOR: skip = (r_step != 4'd2) && (r_step != 4'd10);
                MODE_FRAME:  skip = (r_step != 4'd6);
                default:     skip = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_step    = r_step;
        n_url     = r_url;
        n_text    = r_text;
        n_ovf     = r_ovf;
        n_event   = EV_NONE;
        n_echo    = '0;
        want_url  = 1'b0;
        want_text = 1'b0;
        done      = 1'b0;
        if (!skip) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (r_step == 4'd0) begin
                        if (i_cls.lt) n_step = 4'd1;
                    end else if (r_step == 4'd1) begin
                        if (i_cls.l_a) begin
                            n_step = 4'd2;
                            n_mode = MODE_ANCHOR;
                        end else if (i_cls.l_f) begin
                            n_step = 4'd2;
                            n_mode = MODE_FRAME;
                        end else begin
                            n_step = 4'd0;
                        end
                    end else begin
                        n_step = 4'd0;
                    end
                end
                MODE_ANCHOR: begin
                    case (r_step)
                        4'd2: n_step = i_cls.ws ? 4'd3 : 4'd0;
                        4'd3: begin
                            if (i_cls.l_h) n_step = 4'd4;
                            else if (i_cls.gt) n_step = 4'd0;
                        end
                        4'd4: n_step = i_cls.l_r ? 4'd5 : 4'd3;
                        4'd5: n_step = i_cls.l_e ? 4'd6 : 4'd3;
                        4'd6: n_step = i_cls.l_f ? 4'd7 : 4'd3;
                        4'd7: n_step = i_cls.eq ? 4'd8 : 4'd0;
                        4'd8: begin
                            if (i_cls.quote) begin
                                n_step = 4'd9;
                            end else begin
                                n_step   = 4'd10;
                                want_url = 1'b1;
                            end
                        end
                        4'd9: begin
                            if (i_cls.quote) n_step = 4'd10;
                            else want_url = 1'b1;
                        end
                        4'd10: begin
                            if (i_cls.gt) begin
                                n_step = 4'd1;
                                n_mode = MODE_TEXT;
                            end else begin
                                want_url = 1'b1;
                            end
                        end
                        default: n_step = 4'd0;
                    endcase
                end
                MODE_FRAME: begin
                    case (r_step)
                        4'd2:  n_step = i_cls.l_r ? 4'd3 : 4'd0;
                        4'd3:  n_step = i_cls.l_a ? 4'd4 : 4'd0;
                        4'd4:  n_step = i_cls.l_m ? 4'd5 : 4'd0;
                        4'd5:  n_step = i_cls.l_e ? 4'd6 : 4'd0;
                        4'd6:  n_step = i_cls.ws ? 4'd7 : 4'd0;
                        4'd7:  n_step = i_cls.l_s ? 4'd8 : 4'd7;
                        4'd8:  n_step = i_cls.l_r ? 4'd9 : 4'd7;
                        4'd9:  n_step = i_cls.l_c ? 4'd10 : 4'd7;
                        4'd10: n_step = i_cls.eq ? 4'd11 : 4'd7;
                        4'd11: n_step = i_cls.quote ? 4'd12 : 4'd0;
                        4'd12: begin
                            if (i_cls.quote) begin
                                n_step  = 4'd0;
                                n_event = EV_FRAME_DONE;
                                done    = 1'b1;
                            end else begin
                                want_url = 1'b1;
                            end
                        end
                        default: n_step = 4'd0;
                    endcase
                end
                MODE_TEXT: begin
                    case (r_step)
                        4'd1: begin
                            if (i_cls.lt) n_step = 4'd2;
                            else want_text = 1'b1;
                        end
                        4'd2: n_step = i_cls.slash ? 4'd3 : 4'd5;
                        4'd3: n_step = i_cls.l_a ? 4'd4 : 4'd5;
                        4'd4: begin
                            if (i_cls.gt || i_cls.ws) begin
                                n_step  = 4'd0;
                                n_event = EV_ANCHOR_DONE;
                                done    = 1'b1;
                            end
                        end
                        4'd5: begin
                            if (i_cls.gt) n_step = 4'd1;
                        end
                        default: n_step = 4'd0;
                    endcase
                end
                default: n_step = 4'd0;
            endcase

            // saturating collection; a byte at the limit is dropped
            if (want_url) begin
                if (r_url >= URL_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_url   = URL_LEN_W'(r_url + 1'b1);
                    n_echo  = i_cls.data;
                    n_event = EV_URL;
                end
            end
            if (want_text) begin
                if (r_text >= TEXT_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_text  = TEXT_LEN_W'(r_text + 1'b1);
                    n_echo  = i_cls.data;
                    n_event = EV_TEXT;
                end
            end
            if (n_step == 4'd0) begin
                n_mode = MODE_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_step      <= '0;
            r_url       <= '0;
            r_text      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_mode <= n_mode;
                r_step <= n_step;
                // done beat reports final lengths, then the link state clears
                if (done) begin
                    r_url  <= '0;
                    r_text <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_url  <= n_url;
                    r_text <= n_text;
                    r_ovf  <= n_ovf;
                end
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_event    <= n_event;
            r_echo     <= n_echo;
            r_url_len  <= n_url;
            r_text_len <= n_text;
            r_out_ovf  <= n_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_kind  = r_event;
    assign o_out.out_byte    = r_echo;
    assign o_out.url_length  = r_url_len;
    assign o_out.text_length = r_text_len;
    assign o_out.overflow    = r_out_ovf;

endmodule

// File: hw/rtl/html_link_tag_scanner_core.sv
// ----------------------------------------------------------------------------
// html_link_tag_scanner_core
// Finds anchor href and frame src links in an HTML byte stream.
// ----------------------------------------------------------------------------
// Path: each input byte is written into the queue, then the back registers the result beat.
// Throughput: one byte per cycle while the output is not stalled.
// The two-entry queue and the output register let input and output stall apart.
// Reset (synchronous, active low) clears the matcher, counts and queue;
// no clearing pass, input accepted as soon as reset is released.
// ----------------------------------------------------------------------------
module html_link_tag_scanner_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlts_in_if.sink    i_in,
    hlts_out_if.source o_out
);
    import hlts_pkg::*;

    t_cls   front_cls;
    t_cls   q_cls;
    logic   push;
    logic   q_ready;
    logic   q_valid;
    logic   q_pop;

    hlts_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cls     (front_cls)
    );

    hlts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_cls   (q_cls),
        .o_valid (q_valid)
    );

    hlts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (q_cls),
        .i_cls_valid (q_valid),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

// File: hw/rtl/hlts_checker.sv
// ----------------------------------------------------------------------------
// hlts_checker
// Port-level checks on the result channel of the scanner.
// ----------------------------------------------------------------------------
module hlts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [hlts_pkg::EVENT_W-1:0]    i_event_kind,
    input logic [hlts_pkg::BYTE_W-1:0]     i_out_byte,
    input logic [hlts_pkg::URL_LEN_W-1:0]  i_url_length,
    input logic [hlts_pkg::TEXT_LEN_W-1:0] i_text_length
);
    import hlts_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_kind)
            && $stable(i_out_byte) && $stable(i_url_length))
        else $error("result beat changed while stalled");

    a_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind != EV_URL && i_event_kind != EV_TEXT
            |-> i_out_byte == '0)
        else $error("echo byte set on non-data event");

    a_url_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind == EV_URL
            |-> i_url_length != '0 && i_url_length <= URL_MAX)
        else $error("url beat with bad length");

    a_text_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_kind == EV_TEXT
            |-> i_text_length != '0 && i_text_length <= TEXT_MAX)
        else $error("text beat with bad length");

endmodule

bind html_link_tag_scanner_core hlts_checker u_hlts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_kind  (o_out.event_kind),
    .i_out_byte    (o_out.out_byte),
    .i_url_length  (o_out.url_length),
    .i_text_length (o_out.text_length)
);

// File: dv/html_link_tag_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// html_link_tag_scanner_core_tb
// Drives HTML byte streams into the link scanner and checks every result beat
// against a cycle-free model of the matcher: directed anchor and frame links,
// saturation of both lengths, then randomised well-formed, broken and noisy
// markup with random stalls on both channels.
// ----------------------------------------------------------------------------
module html_link_tag_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hlts_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 950;

    localparam logic [1:0] SCAN_IDLE   = 2'd0;
    localparam logic [1:0] SCAN_ANCHOR = 2'd1;
    localparam logic [1:0] SCAN_FRAME  = 2'd2;
    localparam logic [1:0] SCAN_TEXT   = 2'd3;

    typedef struct packed {
        logic [EVENT_W-1:0]    kind;
        logic [BYTE_W-1:0]     echo;
        logic [URL_LEN_W-1:0]  url_len;
        logic [TEXT_LEN_W-1:0] text_len;
        logic                  ovf;
    } t_link_beat;

    logic clk;
    logic rst_n;

    hlts_in_if  in_if ();
    hlts_out_if out_if ();

    html_link_tag_scanner_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // matcher state mirrored here
    logic [1:0]            sc_mode;
    logic [STEP_W-1:0]     sc_step;
    logic [URL_LEN_W-1:0]  url_cnt;
    logic [TEXT_LEN_W-1:0] text_cnt;
    logic                  ovf_seen;

    t_link_beat  expected_beats[$];
    logic [7:0]  pending[$];
    int          n_sent;
    int          n_beats;
    int          n_fail;
    int          cycles;
    int          out_stall;
    bit          steady;

    initial clk = 1'b0;
    always #5ns clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit is_ch(logic [7:0] b, logic [7:0] lc);
        return (b | CH_CASE) == lc;
    endfunction

    function automatic logic [EVENT_W-1:0] collect_url();
        if (url_cnt >= URL_MAX) begin
            ovf_seen = 1'b1;
            return EV_NONE;
        end
        url_cnt++;
        return EV_URL;
    endfunction

    function automatic logic [EVENT_W-1:0] collect_text();
        if (text_cnt >= TEXT_MAX) begin
            ovf_seen = 1'b1;
            return EV_NONE;
        end
        text_cnt++;
        return EV_TEXT;
    endfunction

    function automatic t_link_beat scan_byte(logic [7:0] b);
        t_link_beat        r;
        logic [STEP_W-1:0] s;
        bit                ws;
        bit                skip;
        bit                done;
        r    = '0;
        r.kind = EV_NONE;
        s    = sc_step;
        ws   = (b <= CH_BLANK);
        done = 1'b0;
        case (sc_mode)
            SCAN_IDLE:   skip = ws;
            SCAN_ANCHOR: skip = ws && s != 4'd2 && s != 4'd10;
            SCAN_FRAME:  skip = ws && s != 4'd6;
            default:     skip = 1'b0;
        endcase
        if (!skip) begin
            case (sc_mode)
                SCAN_IDLE: begin
                    if (s == 4'd0) begin
                        if (b == CH_LT) s = 4'd1;
                    end else if (s == 4'd1) begin
                        if (is_ch(b, "a")) begin
                            s = 4'd2;
                            sc_mode = SCAN_ANCHOR;
                        end else if (is_ch(b, "f")) begin
                            s = 4'd2;
                            sc_mode = SCAN_FRAME;
                        end else begin
                            s = 4'd0;
                        end
                    end else begin
                        s = 4'd0;
                    end
                end
                SCAN_ANCHOR: begin
                    case (s)
                        4'd2: s = ws ? 4'd3 : 4'd0;
                        4'd3: begin
                            if (is_ch(b, "h")) s = 4'd4;
                            else if (b == CH_GT) s = 4'd0;
                        end
                        4'd4: s = is_ch(b, "r") ? 4'd5 : 4'd3;
                        4'd5: s = is_ch(b, "e") ? 4'd6 : 4'd3;
                        4'd6: s = is_ch(b, "f") ? 4'd7 : 4'd3;
                        4'd7: s = (b == CH_EQ) ? 4'd8 : 4'd0;
                        4'd8: begin
                            if (b == CH_QUOTE) begin
                                s = 4'd9;
                            end else begin
                                s = 4'd10;
                                r.kind = collect_url();
                            end
                        end
                        4'd9: begin
                            if (b == CH_QUOTE) s = 4'd10;
                            else r.kind = collect_url();
                        end
                        4'd10: begin
                            if (b == CH_GT) begin
                                s = 4'd1;
                                sc_mode = SCAN_TEXT;
                            end else begin
                                r.kind = collect_url();
                            end
                        end
                        default: s = 4'd0;
                    endcase
                end
                SCAN_FRAME: begin
                    case (s)
                        4'd2:  s = is_ch(b, "r") ? 4'd3 : 4'd0;
                        4'd3:  s = is_ch(b, "a") ? 4'd4 : 4'd0;
                        4'd4:  s = is_ch(b, "m") ? 4'd5 : 4'd0;
                        4'd5:  s = is_ch(b, "e") ? 4'd6 : 4'd0;
                        4'd6:  s = ws ? 4'd7 : 4'd0;
                        4'd7:  s = is_ch(b, "s") ? 4'd8 : 4'd7;
                        4'd8:  s = is_ch(b, "r") ? 4'd9 : 4'd7;
                        4'd9:  s = is_ch(b, "c") ? 4'd10 : 4'd7;
                        4'd10: s = (b == CH_EQ) ? 4'd11 : 4'd7;
                        4'd11: s = (b == CH_QUOTE) ? 4'd12 : 4'd0;
                        4'd12: begin
                            if (b == CH_QUOTE) begin
                                s = 4'd0;
                                r.kind = EV_FRAME_DONE;
                                done = 1'b1;
                            end else begin
                                r.kind = collect_url();
                            end
                        end
                        default: s = 4'd0;
                    endcase
                end
                default: begin
                    case (s)
                        4'd1: begin
                            if (b == CH_LT) s = 4'd2;
                            else r.kind = collect_text();
                        end
                        4'd2: s = (b == CH_SLASH) ? 4'd3 : 4'd5;
                        4'd3: s = is_ch(b, "a") ? 4'd4 : 4'd5;
                        4'd4: begin
                            if (b == CH_GT || ws) begin
                                s = 4'd0;
                                r.kind = EV_ANCHOR_DONE;
                                done = 1'b1;
                            end
                        end
                        4'd5: begin
                            if (b == CH_GT) s = 4'd1;
                        end
                        default: s = 4'd0;
                    endcase
                end
            endcase
            if (s == 4'd0) sc_mode = SCAN_IDLE;
            sc_step = s;
        end
        if (r.kind == EV_URL || r.kind == EV_TEXT) r.echo = b;
        r.url_len  = url_cnt;
        r.text_len = text_cnt;
        r.ovf      = ovf_seen;
        if (done) begin
            url_cnt  = '0;
            text_cnt = '0;
            ovf_seen = 1'b0;
            sc_mode  = SCAN_IDLE;
            sc_step  = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] mix_case(logic [7:0] c);
        logic [7:0] low;
        low = c | CH_CASE;
        if (low >= "a" && low <= "z" && $urandom_range(0, 1) == 1) return c ^ CH_CASE;
        return c;
    endfunction

    function automatic void push_raw(string w);
        for (int i = 0; i < w.len(); i++) pending.push_back(w[i]);
    endfunction

    function automatic void push_word(string w);
        for (int i = 0; i < w.len(); i++) pending.push_back(mix_case(w[i]));
    endfunction

    function automatic void push_blanks(int lo);
        int n;
        n = $urandom_range(lo, 2);
        repeat (n) pending.push_back($urandom_range(0, 2) != 0 ? CH_BLANK
                                                               : 8'($urandom_range(0, 32)));
    endfunction

    function automatic int url_size();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 8);
        return $urandom_range(9, 40);
    endfunction

    function automatic void push_anchor(bit quoted);
        int n;
        push_word("<a");
        push_blanks(1);
        if ($urandom_range(0, 3) == 0) begin
            push_word("id=k");
            push_blanks(1);
        end
        push_word("href=");
        if (quoted) begin
            pending.push_back(CH_QUOTE);
            repeat (url_size()) pending.push_back(pick_other(CH_QUOTE));
            pending.push_back(CH_QUOTE);
            if ($urandom_range(0, 4) == 0) push_blanks(0);
        end else begin
            repeat (url_size() + 1) pending.push_back(pick_other(CH_GT));
        end
        pending.push_back(CH_GT);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       push_word("<b>");
                1:       push_word("</i>");
                default: pending.push_back(pick_other(CH_LT));
            endcase
        end
        push_word("</a");
        if ($urandom_range(0, 2) == 0) pending.push_back(8'($urandom_range(0, 32)));
        else pending.push_back(CH_GT);
    endfunction

    function automatic void push_frame();
        push_word("<frame");
        push_blanks(1);
        if ($urandom_range(0, 3) == 0) begin
            push_word("name=x");
            push_blanks(1);
        end
        push_word("src=\"");
        repeat (url_size()) pending.push_back(pick_other(CH_QUOTE));
        pending.push_back(CH_QUOTE);
    endfunction

    function automatic void push_noise();
        repeat ($urandom_range(1, 8)) pending.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // channel handling
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        expected_beats.push_back(scan_byte(b));
        n_sent++;
    endtask

    task automatic send_pending();
        while (pending.size() != 0) send_byte(pending.pop_front());
    endtask

    // drop valid and let every outstanding beat come back
    task automatic settle();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
    endtask

    always @(negedge clk) begin
        if (out_stall != 0) begin
            out_if.ready <= 1'b0;
            out_stall--;
        end else begin
            out_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) out_stall = pick_gap();
        end
    end

    function automatic void note_fail(string msg);
        n_fail++;
        if (n_fail <= 10) $display("%s", msg);
    endfunction

    always @(posedge clk) begin
        t_link_beat got;
        t_link_beat want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.kind     = out_if.event_kind;
            got.echo     = out_if.out_byte;
            got.url_len  = out_if.url_length;
            got.text_len = out_if.text_length;
            got.ovf      = out_if.overflow;
            n_beats++;
            if (expected_beats.size() == 0) begin
                note_fail($sformatf("beat %0d: result with nothing expected", n_beats));
            end else begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind || got.echo !== want.echo ||
                    got.url_len !== want.url_len || got.text_len !== want.text_len ||
                    got.ovf !== want.ovf) begin
                    note_fail($sformatf({"beat %0d: expected kind=%0d byte=%02h url=%0d ",
                        "text=%0d ovf=%b, got kind=%0d byte=%02h url=%0d text=%0d ovf=%b"},
                        n_beats, want.kind, want.echo, want.url_len, want.text_len,
                        want.ovf, got.kind, got.echo, got.url_len, got.text_len, got.ovf));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // byte extremes, unquoted href with a blank kept, close on a blank
    task automatic test_unquoted_anchor();
        pending.push_back(8'h00);
        pending.push_back(8'hFF);
        push_raw("<A HrEf=u v>t</a\t");
        send_pending();
    endtask

    // blanks inside a quoted src are dropped
    task automatic test_quoted_frame();
        push_raw("<fRaMe\tsrc=\" g\"");
        send_pending();
        settle();
    endtask

    // both lengths run past their limits, then a short link shows the flag cleared
    task automatic test_length_limits();
        push_word("<a href=\"");
        repeat (int'(URL_MAX) + 6) begin
            logic [7:0] c;
            do c = 8'($urandom_range(33, 255)); while (c == CH_QUOTE);
            pending.push_back(c);
        end
        push_word("\">");
        repeat (int'(TEXT_MAX) + 5) pending.push_back(pick_other(CH_LT));
        push_word("</a>");
        push_word("<frame src=\"ok\"");
        send_pending();
        settle();
    endtask

    task automatic test_random_links();
        int  stop_at;
        int  next_swap;
        bit  drained;
        int  keep;
        stop_at   = n_sent + RANDOM_ITEMS;
        next_swap = n_sent + 100;
        drained   = 1'b0;
        while (n_sent < stop_at) begin
            case ($urandom_range(0, 99)) inside
                [0:39]:  push_anchor(1'b1);
                [40:54]: push_anchor(1'b0);
                [55:74]: push_frame();
                [75:86]: begin
                    // cut a link short and follow it with junk
                    if ($urandom_range(0, 1) == 1) push_frame();
                    else push_anchor(1'($urandom_range(0, 1)));
                    keep = $urandom_range(1, pending.size() - 1);
                    while (pending.size() > keep) void'(pending.pop_back());
                    push_noise();
                end
                default: push_noise();
            endcase
            send_pending();
            if (n_sent >= next_swap) begin
                steady    = ($urandom_range(0, 3) == 0);
                next_swap = n_sent + $urandom_range(60, 150);
            end
            if (!drained && n_sent >= stop_at - RANDOM_ITEMS / 2) begin
                settle();
                drained = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        out_if.ready    = 1'b0;
        sc_mode         = SCAN_IDLE;
        sc_step         = '0;
        url_cnt         = '0;
        text_cnt        = '0;
        ovf_seen        = 1'b0;
        n_sent          = 0;
        n_beats         = 0;
        n_fail          = 0;
        cycles          = 0;
        out_stall       = 0;
        steady          = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unquoted_anchor();
        test_quoted_frame();
        test_length_limits();
        test_random_links();

        settle();
        repeat (6) @(posedge clk);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/hlts_pkg.sv
hw/rtl/hlts_if.sv
hw/rtl/hlts_front.sv
hw/rtl/hlts_queue.sv
hw/rtl/hlts_back.sv
hw/rtl/html_link_tag_scanner_core.sv
hw/rtl/hlts_checker.sv
dv/html_link_tag_scanner_core_tb.sv
